// File: src/qpb_pkg.sv
// ----------------------------------------------------------------------------
// qpb_pkg
// Shared widths, register codes, configuration bundle and field helpers for
// the pose to base frame pipeline.
// ----------------------------------------------------------------------------
package qpb_pkg;

    localparam int COEF_W     = 18;
    localparam int POS_W      = 21;
    localparam int BASE_W     = 23;
    localparam int DIR_W      = 16;
    localparam int QUAT_W     = 16;

    localparam int DIV_NUM_W  = 50;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_Q_W    = 17;

    localparam int SQ_ROOT_W  = 28;
    localparam int SQ_ACC_W   = 57;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int ROW_W      = 54;
    localparam int VEC_W      = 63;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_TRANS  = 3'd3,
        REG_OFFSET = 3'd4
    } reg_idx_t;

    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(65536);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(65536) << 18;
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(65536) << 36;

    typedef struct packed {
        logic [ROW_W-1:0] row0;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
        logic [VEC_W-1:0] trans;
        logic [VEC_W-1:0] offset;
    } cfg_t;

    function automatic logic signed [COEF_W-1:0] coef(cfg_t c, int i, int j);
        logic [ROW_W-1:0] row;
        row = (i == 0) ? c.row0 : ((i == 1) ? c.row1 : c.row2);
        return $signed(row[COEF_W*j +: COEF_W]);
    endfunction

    function automatic logic signed [POS_W-1:0] vec_field(logic [VEC_W-1:0] v, int i);
        return $signed(v[POS_W*i +: POS_W]);
    endfunction

endpackage

// File: src/qpb_cfg.sv
// ----------------------------------------------------------------------------
// qpb_cfg
// APB register file holding the calibration rotation, translation and offset.
// ----------------------------------------------------------------------------
module qpb_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qpb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [qpb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [qpb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output qpb_pkg::cfg_t                      cfg_o
);

    qpb_pkg::cfg_t     cfg_reg;
    qpb_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = qpb_pkg::reg_idx_t'(paddr[qpb_pkg::CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg_o  = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row0   <= qpb_pkg::ROW0_RST;
            cfg_reg.row1   <= qpb_pkg::ROW1_RST;
            cfg_reg.row2   <= qpb_pkg::ROW2_RST;
            cfg_reg.trans  <= '0;
            cfg_reg.offset <= '0;
        end else if (wr_en) begin
            case (idx)
                qpb_pkg::REG_ROW0:   cfg_reg.row0   <= pwdata[qpb_pkg::ROW_W-1:0];
                qpb_pkg::REG_ROW1:   cfg_reg.row1   <= pwdata[qpb_pkg::ROW_W-1:0];
                qpb_pkg::REG_ROW2:   cfg_reg.row2   <= pwdata[qpb_pkg::ROW_W-1:0];
                qpb_pkg::REG_TRANS:  cfg_reg.trans  <= pwdata[qpb_pkg::VEC_W-1:0];
                qpb_pkg::REG_OFFSET: cfg_reg.offset <= pwdata[qpb_pkg::VEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            qpb_pkg::REG_ROW0:   prdata = qpb_pkg::CFG_DATA_W'(cfg_reg.row0);
            qpb_pkg::REG_ROW1:   prdata = qpb_pkg::CFG_DATA_W'(cfg_reg.row1);
            qpb_pkg::REG_ROW2:   prdata = qpb_pkg::CFG_DATA_W'(cfg_reg.row2);
            qpb_pkg::REG_TRANS:  prdata = qpb_pkg::CFG_DATA_W'(cfg_reg.trans);
            qpb_pkg::REG_OFFSET: prdata = qpb_pkg::CFG_DATA_W'(cfg_reg.offset);
            default:             prdata = '0;
        endcase
    end

endmodule

// File: src/qpb_div.sv
// ----------------------------------------------------------------------------
// qpb_div
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// ----------------------------------------------------------------------------
module qpb_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [qpb_pkg::DIV_NUM_W-1:0]     num_i,
    input  logic [qpb_pkg::DIV_DEN_W-1:0]     den_i,
    output logic [qpb_pkg::DIV_Q_W-1:0]       quo_o
);

    localparam int NW = qpb_pkg::DIV_NUM_W;
    localparam int DW = qpb_pkg::DIV_DEN_W;
    localparam int QW = qpb_pkg::DIV_Q_W;

    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [NW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [NW-1:0] rem_in   [QW];
    logic [NW-1:0] sub_val  [QW];
    logic [DW-1:0] den_in   [QW];
    logic [QW-1:0] quo_in   [QW];

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                rem_in[s] = num_i;
                den_in[s] = den_i;
                quo_in[s] = '0;
            end else begin
                rem_in[s] = rem_reg[s-1];
                den_in[s] = den_reg[s-1];
                quo_in[s] = quo_reg[s-1];
            end
            sub_val[s] = NW'(den_in[s]) << (QW - 1 - s);
            if (rem_in[s] >= sub_val[s]) begin
                rem_next[s] = rem_in[s] - sub_val[s];
                quo_next[s] = quo_in[s] | (QW'(1) << (QW - 1 - s));
            end else begin
                rem_next[s] = rem_in[s];
                quo_next[s] = quo_in[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QW; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_in[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo_o = quo_reg[QW-1];

endmodule

// File: src/qpb_isqrt.sv
// ----------------------------------------------------------------------------
// qpb_isqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module qpb_isqrt (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [qpb_pkg::SQ_ACC_W-2:0]      val_i,
    output logic [qpb_pkg::SQ_ROOT_W-1:0]     root_o
);

    localparam int AW = qpb_pkg::SQ_ACC_W;
    localparam int RW = qpb_pkg::SQ_ROOT_W;

    logic [AW-1:0] v_reg  [RW];
    logic [AW-1:0] r_reg  [RW];
    logic [AW-1:0] v_next [RW];
    logic [AW-1:0] r_next [RW];
    logic [AW-1:0] v_in   [RW];
    logic [AW-1:0] r_in   [RW];
    logic [AW-1:0] bit_v  [RW];
    logic [AW-1:0] trial  [RW];

    always_comb begin
        for (int s = 0; s < RW; s++) begin
            if (s == 0) begin
                v_in[s] = {1'b0, val_i};
                r_in[s] = '0;
            end else begin
                v_in[s] = v_reg[s-1];
                r_in[s] = r_reg[s-1];
            end
            bit_v[s] = AW'(1) << (2 * (RW - 1 - s));
            trial[s] = r_in[s] + bit_v[s];
            if (v_in[s] >= trial[s]) begin
                v_next[s] = v_in[s] - trial[s];
                r_next[s] = (r_in[s] >> 1) + bit_v[s];
            end else begin
                v_next[s] = v_in[s];
                r_next[s] = r_in[s] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < RW; s++) begin
                v_reg[s] <= v_next[s];
                r_reg[s] <= r_next[s];
            end
        end
    end

    assign root_o = r_reg[RW-1][RW-1:0];

endmodule

// File: src/quaternion_pose_to_base_frame_top.sv
// ----------------------------------------------------------------------------
// quaternion_pose_to_base_frame_top
// Maps one tracker sample (position, quaternion) to a base frame position
// and a unit tool direction.
//
// Input stream: s_tdata carries position and quaternion; one sample per
// transfer. Output stream: m_tdata carries base position and direction,
// m_tuser the degenerate-quaternion and position-saturated flags. Each
// input transfer yields exactly one output transfer, in order.
// One sample can enter every cycle unless the output stalls. The pipeline
// contains the 17-stage quotient divider for the rotation column, the
// 28-stage square root for the direction length and the 17-stage divider
// that normalizes the direction.
// All stages share one advance enable: when m_tready is low while a result
// is held, the whole pipeline holds and s_tready drops; nothing is lost.
// Reset clears all valid bits and loads the identity calibration with zero
// translation and offset. Registers are written over APB at 8-byte steps.
// ----------------------------------------------------------------------------
module quaternion_pose_to_base_frame_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, zero pad
    input  logic [127:0]                       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // base_x, base_y, base_z, dir_x, dir_y, dir_z, zero pad
    output logic [119:0]                       m_tdata,
    // quat_degenerate, pos_saturated
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qpb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [qpb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [qpb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int NW = qpb_pkg::DIV_NUM_W;
    localparam int DW = qpb_pkg::DIV_DEN_W;
    localparam int QW = qpb_pkg::DIV_Q_W;
    localparam int RW = qpb_pkg::SQ_ROOT_W;
    localparam int PW = qpb_pkg::POS_W;
    localparam int BW = qpb_pkg::BASE_W;
    localparam int CW = qpb_pkg::COEF_W;
    localparam int OW = qpb_pkg::DIR_W;
    localparam int DVW = 29;

    typedef struct packed {
        logic            vld;
        logic [3*PW-1:0] pos;
        logic            degen;
        logic [2:0]      neg;
    } sb1_t;

    typedef struct packed {
        logic             vld;
        logic [3*BW-1:0]  base;
        logic             degen;
        logic             sat;
        logic [3*DVW-1:0] d;
    } sb2_t;

    typedef struct packed {
        logic            vld;
        logic [3*BW-1:0] base;
        logic            degen;
        logic            sat;
        logic [2:0]      neg;
        logic            zero;
    } sb3_t;

    qpb_pkg::cfg_t cfg;
    logic          adv;

    qpb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    logic m_tvalid_reg;
    logic [119:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Stage 1: quaternion products
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = $signed(s_tdata[78:63]);
    assign qx = $signed(s_tdata[94:79]);
    assign qy = $signed(s_tdata[110:95]);
    assign qz = $signed(s_tdata[126:111]);

    logic                v1_reg;
    logic [3*PW-1:0]     p1_reg;
    logic signed [31:0]  ww_reg, xx_reg, yy_reg, zz_reg, xz_reg, yw_reg, yz_reg, xw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= s_tdata[3*PW-1:0];
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xz_reg <= qx * qz;
            yw_reg <= qy * qw;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
        end
    end

    // Stage 2: norm and column numerators
    logic               v2_reg;
    logic [3*PW-1:0]    p2_reg;
    logic [32:0]        n2_reg;
    logic signed [32:0] s0_reg, s1_reg;
    logic signed [33:0] s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg <= p1_reg;
            n2_reg <= 33'(34'(ww_reg) + 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg));
            s0_reg <= 33'(xz_reg) + 33'(yw_reg);
            s1_reg <= 33'(yz_reg) - 33'(xw_reg);
            s2_reg <= 34'(ww_reg) + 34'(zz_reg) - 34'(xx_reg) - 34'(yy_reg);
        end
    end

    // Stage 3: rounded magnitudes into the column divider
    logic signed [32:0] a0, a1;
    logic signed [33:0] a2;
    logic [NW-1:0]      half_n2;
    logic [NW-1:0]      mag3_next [3];

    always_comb begin
        a0 = s0_reg[32] ? -s0_reg : s0_reg;
        a1 = s1_reg[32] ? -s1_reg : s1_reg;
        a2 = s2_reg[33] ? -s2_reg : s2_reg;
        half_n2 = NW'(n2_reg[32:1]);
        mag3_next[0] = (NW'(a0[31:0]) << 17) + half_n2;
        mag3_next[1] = (NW'(a1[31:0]) << 17) + half_n2;
        mag3_next[2] = (NW'(a2[32:0]) << 16) + half_n2;
    end

    logic          v3_reg;
    logic [3*PW-1:0] p3_reg;
    logic          degen3_reg;
    logic [2:0]    neg3_reg;
    logic [NW-1:0] mag3_reg [3];
    logic [DW-1:0] den3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_reg     <= p2_reg;
            degen3_reg <= (n2_reg == '0);
            neg3_reg   <= {s2_reg[33], s1_reg[32], s0_reg[32]};
            for (int i = 0; i < 3; i++) mag3_reg[i] <= mag3_next[i];
            den3_reg   <= (n2_reg == '0) ? DW'(1) : n2_reg;
        end
    end

    logic [QW-1:0] quo1 [3];
    for (genvar g = 0; g < 3; g++) begin : g_coldiv
        qpb_div u_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (mag3_reg[g]),
            .den_i (den3_reg),
            .quo_o (quo1[g])
        );
    end

    sb1_t sb1_reg [QW];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < QW; s++) sb1_reg[s] <= '0;
        end else if (adv) begin
            sb1_reg[0] <= '{vld: v3_reg, pos: p3_reg, degen: degen3_reg, neg: neg3_reg};
            for (int s = 1; s < QW; s++) sb1_reg[s] <= sb1_reg[s-1];
        end
    end

    // Stage 4: signed rotation column
    logic                 v4_reg;
    logic [3*PW-1:0]      p4_reg;
    logic                 degen4_reg;
    logic signed [CW-1:0] col4_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= sb1_reg[QW-1].vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_reg     <= sb1_reg[QW-1].pos;
            degen4_reg <= sb1_reg[QW-1].degen;
            for (int i = 0; i < 3; i++) begin
                if (sb1_reg[QW-1].degen) begin
                    col4_reg[i] <= (i == 2) ? CW'(65536) : '0;
                end else if (sb1_reg[QW-1].neg[i]) begin
                    col4_reg[i] <= -$signed({1'b0, quo1[i]});
                end else begin
                    col4_reg[i] <= $signed({1'b0, quo1[i]});
                end
            end
        end
    end

    // Stage 5: calibration products
    logic               v5_reg;
    logic               degen5_reg;
    logic signed [38:0] cp5_reg [3][3];
    logic signed [35:0] cd5_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen5_reg <= degen4_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cp5_reg[i][j] <= qpb_pkg::coef(cfg, i, j) *
                                     $signed(p4_reg[PW*j +: PW]);
                    cd5_reg[i][j] <= qpb_pkg::coef(cfg, i, j) * col4_reg[j];
                end
            end
        end
    end

    // Stage 6: row sums
    logic               v6_reg;
    logic               degen6_reg;
    logic signed [40:0] sp6_reg [3];
    logic signed [37:0] sd6_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen6_reg <= degen5_reg;
            for (int i = 0; i < 3; i++) begin
                sp6_reg[i] <= 41'(cp5_reg[i][0]) + 41'(cp5_reg[i][1]) + 41'(cp5_reg[i][2]);
                sd6_reg[i] <= 38'(cd5_reg[i][0]) + 38'(cd5_reg[i][1]) + 38'(cd5_reg[i][2]);
            end
        end
    end

    // Stage 7: round position to integer and direction to Q.24
    logic signed [40:0]  asp [3];
    logic signed [37:0]  asd [3];
    logic [39:0]         rp  [3];
    logic [36:0]         rd  [3];
    logic signed [24:0]  bq7_next [3];
    logic signed [DVW-1:0] d7_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            asp[i] = sp6_reg[i][40] ? -sp6_reg[i] : sp6_reg[i];
            asd[i] = sd6_reg[i][37] ? -sd6_reg[i] : sd6_reg[i];
            rp[i]  = asp[i][39:0] + 40'd32768;
            rd[i]  = asd[i][36:0] + 37'd128;
            bq7_next[i] = sp6_reg[i][40] ? -$signed({1'b0, rp[i][39:16]})
                                         : $signed({1'b0, rp[i][39:16]});
            d7_next[i]  = sd6_reg[i][37] ? -$signed({1'b0, rd[i][35:8]})
                                         : $signed({1'b0, rd[i][35:8]});
        end
    end

    logic                  v7_reg;
    logic                  degen7_reg;
    logic signed [24:0]    bq7_reg [3];
    logic signed [DVW-1:0] d7_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen7_reg <= degen6_reg;
            for (int i = 0; i < 3; i++) begin
                bq7_reg[i] <= bq7_next[i];
                d7_reg[i]  <= d7_next[i];
            end
        end
    end

    // Stage 8: offsets, saturation, direction squares
    logic signed [26:0]       bsum [3];
    logic [BW-1:0]            base8_next [3];
    logic [2:0]               clip;
    logic signed [2*DVW-1:0]  dsq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bsum[i] = 27'(bq7_reg[i]) + 27'(qpb_pkg::vec_field(cfg.trans, i))
                    + 27'(qpb_pkg::vec_field(cfg.offset, i));
            dsq[i]  = d7_reg[i] * d7_reg[i];
            if (bsum[i] > 27'sd4194303) begin
                base8_next[i] = BW'(4194303);
                clip[i]       = 1'b1;
            end else if (bsum[i] < -27'sd4194304) begin
                base8_next[i] = BW'(4194304);
                clip[i]       = 1'b1;
            end else begin
                base8_next[i] = bsum[i][BW-1:0];
                clip[i]       = 1'b0;
            end
        end
    end

    logic                  v8_reg;
    logic                  degen8_reg;
    logic                  sat8_reg;
    logic [3*BW-1:0]       base8_reg;
    logic [3*DVW-1:0]      d8_reg;
    logic [55:0]           sq8_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v7_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen8_reg <= degen7_reg;
            sat8_reg   <= |clip;
            base8_reg  <= {base8_next[2], base8_next[1], base8_next[0]};
            d8_reg     <= {d7_reg[2], d7_reg[1], d7_reg[0]};
            for (int i = 0; i < 3; i++) sq8_reg[i] <= dsq[i][55:0];
        end
    end

    // Stage 9: squared length
    logic             v9_reg;
    logic             degen9_reg;
    logic             sat9_reg;
    logic [3*BW-1:0]  base9_reg;
    logic [3*DVW-1:0] d9_reg;
    logic [55:0]      l2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (adv) v9_reg <= v8_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen9_reg <= degen8_reg;
            sat9_reg   <= sat8_reg;
            base9_reg  <= base8_reg;
            d9_reg     <= d8_reg;
            l2_reg     <= sq8_reg[0] + sq8_reg[1] + sq8_reg[2];
        end
    end

    logic [RW-1:0] len;
    qpb_isqrt u_isqrt (
        .aclk   (aclk),
        .en     (adv),
        .val_i  (l2_reg),
        .root_o (len)
    );

    sb2_t sb2_reg [RW];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < RW; s++) sb2_reg[s] <= '0;
        end else if (adv) begin
            sb2_reg[0] <= '{vld: v9_reg, base: base9_reg, degen: degen9_reg,
                            sat: sat9_reg, d: d9_reg};
            for (int s = 1; s < RW; s++) sb2_reg[s] <= sb2_reg[s-1];
        end
    end

    // Stage 10: direction magnitudes into the normalizing divider
    logic signed [DVW-1:0] d10 [3];
    logic signed [DVW-1:0] ad10 [3];
    logic [NW-1:0]         mag10_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d10[i]  = $signed(sb2_reg[RW-1].d[DVW*i +: DVW]);
            ad10[i] = d10[i][DVW-1] ? -d10[i] : d10[i];
            mag10_next[i] = (NW'(ad10[i][DVW-2:0]) << 15) + NW'(len[RW-1:1]);
        end
    end

    sb3_t          s10_reg;
    logic [NW-1:0] mag10_reg [3];
    logic [DW-1:0] den10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s10_reg.vld <= 1'b0;
        else if (adv) s10_reg.vld <= sb2_reg[RW-1].vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s10_reg.base  <= sb2_reg[RW-1].base;
            s10_reg.degen <= sb2_reg[RW-1].degen;
            s10_reg.sat   <= sb2_reg[RW-1].sat;
            s10_reg.neg   <= {d10[2][DVW-1], d10[1][DVW-1], d10[0][DVW-1]};
            s10_reg.zero  <= (len == '0);
            for (int i = 0; i < 3; i++) mag10_reg[i] <= mag10_next[i];
            den10_reg     <= (len == '0) ? DW'(1) : DW'(len);
        end
    end

    logic [QW-1:0] quo2 [3];
    for (genvar g = 0; g < 3; g++) begin : g_dirdiv
        qpb_div u_div (
            .aclk  (aclk),
            .en    (adv),
            .num_i (mag10_reg[g]),
            .den_i (den10_reg),
            .quo_o (quo2[g])
        );
    end

    sb3_t sb3_reg [QW];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < QW; s++) sb3_reg[s] <= '0;
        end else if (adv) begin
            sb3_reg[0] <= s10_reg;
            for (int s = 1; s < QW; s++) sb3_reg[s] <= sb3_reg[s-1];
        end
    end

    // Output register: sign, clamp, pack
    logic [OW-1:0] dir_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (sb3_reg[QW-1].zero) begin
                dir_out[i] = '0;
            end else if (sb3_reg[QW-1].neg[i]) begin
                dir_out[i] = OW'(-$signed({1'b0, quo2[i]}));
            end else if (quo2[i] > QW'(32767)) begin
                dir_out[i] = OW'(32767);
            end else begin
                dir_out[i] = quo2[i][OW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (adv) m_tvalid_reg <= sb3_reg[QW-1].vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {3'b000, dir_out[2], dir_out[1], dir_out[0], sb3_reg[QW-1].base};
            m_tuser_reg <= {sb3_reg[QW-1].sat, sb3_reg[QW-1].degen};
        end
    end

endmodule
